FILE: hw/rtl/strr_pkg.sv
package strr_pkg;

    localparam int          SRC_OFF_W  = 13;
    localparam int          DST_OFF_W  = 14;
    localparam logic [3:0]  STYLE_FULL = 4'hF;
    localparam logic [7:0]  STYLE_FLAG = 8'h10;
    localparam logic [13:0] DST_MAX    = 14'h3FFF;

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // register map, index = paddr / 4
    localparam logic [2:0] REG_SET_BITS  = 3'd0;
    localparam logic [2:0] REG_KEEP_MASK = 3'd1;
    localparam logic [2:0] REG_RANGE_BEG = 3'd2;
    localparam logic [2:0] REG_RANGE_END = 3'd3;
    localparam logic [2:0] REG_CURSOR    = 3'd4;

    typedef struct packed {
        logic       action;
        logic [7:0] in_byte;
    } t_in;

    typedef struct packed {
        logic [7:0]           out_byte;
        logic                 byte_valid;
        logic [DST_OFF_W-1:0] cursor_dest;
        logic                 last;
    } t_out;

    typedef struct packed {
        logic [3:0]           style_set_bits;
        logic [3:0]           style_keep_mask;
        logic [SRC_OFF_W-1:0] range_begin;
        logic [SRC_OFF_W-1:0] range_end;
        logic [SRC_OFF_W-1:0] cursor_source;
    } t_cfg;

    // one queued command: optional style byte, 0..4 char bytes, optional final word
    typedef struct packed {
        logic                 style_vld;
        logic [3:0]           style;
        logic [2:0]           nbytes;
        logic [3:0][7:0]      bytes;
        logic                 is_last;
        logic [DST_OFF_W-1:0] cursor;
    } t_cmd;

endpackage

FILE: hw/rtl/styled_text_range_restyler_core.sv
// Channel   | Signals                                  | Moves
// ----------+------------------------------------------+-------------------------------------
// input     | i_in_valid / o_in_ready / i_in_word      | one source byte or end-of-word item
// output    | o_out_valid / i_out_ready / o_out_word   | one emitted byte or the final word
// config    | psel penable pwrite paddr pwdata prdata  | 5 regs at byte offsets 0,4,..,16
//
// Input: one word per cycle as long as the command queue (4 deep) has room.
// Output: one word per cycle from the back end while the queue is non-empty and
//   i_out_ready is high; a source unit expands to at most five output words, so
//   the sustained input rate is set by the output port. Path: queue, then output register.
// Reset: synchronous, active low; clears word state, queue pointers and output valid flag.
// Stalls: output backpressure fills the queue, then drops o_in_ready; the front
//   keeps classifying until the queue is full.
module styled_text_range_restyler_core
    import strr_pkg::*;
#(
    parameter int MAX_WORD_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // source words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_word,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_word,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // config registers
    logic [3:0]           r_set_bits;
    logic [3:0]           r_keep_mask;
    logic [SRC_OFF_W-1:0] r_range_beg;
    logic [SRC_OFF_W-1:0] r_range_end;
    logic [SRC_OFF_W-1:0] r_cursor_src;

    logic       reg_wr;
    logic [2:0] reg_idx;
    t_cfg       cfg;

    // front/queue/back hookup
    logic q_push, q_full, q_pop, q_empty;
    t_cmd q_push_cmd, q_head;

    assign pready  = 1'b1;
    assign reg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= '0;
            r_keep_mask  <= STYLE_FULL;
            r_range_beg  <= '0;
            r_range_end  <= '0;
            r_cursor_src <= '0;
        end else if (reg_wr) begin
            case (reg_idx)
                REG_SET_BITS:  r_set_bits   <= pwdata[3:0];
                REG_KEEP_MASK: r_keep_mask  <= pwdata[3:0];
                REG_RANGE_BEG: r_range_beg  <= pwdata[SRC_OFF_W-1:0];
                REG_RANGE_END: r_range_end  <= pwdata[SRC_OFF_W-1:0];
                REG_CURSOR:    r_cursor_src <= pwdata[SRC_OFF_W-1:0];
                default:       ; // unmapped index, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SET_BITS:  prdata = {28'd0, r_set_bits};
            REG_KEEP_MASK: prdata = {28'd0, r_keep_mask};
            REG_RANGE_BEG: prdata = {19'd0, r_range_beg};
            REG_RANGE_END: prdata = {19'd0, r_range_end};
            REG_CURSOR:    prdata = {19'd0, r_cursor_src};
            default:       prdata = '0;
        endcase
    end

    assign cfg.style_set_bits  = r_set_bits;
    assign cfg.style_keep_mask = r_keep_mask;
    assign cfg.range_begin     = r_range_beg;
    assign cfg.range_end       = r_range_end;
    assign cfg.cursor_source   = r_cursor_src;

    // front: UTF-8 unit assembly, classification, style/offset bookkeeping
    strr_front #(
        .MAX_WORD_BYTES (MAX_WORD_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_push_cmd (q_push_cmd)
    );

    // command queue decouples the two sides
    strr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_push_cmd),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_empty    (q_empty),
        .o_head     (q_head)
    );

    // back: serializes each command into output words
    strr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

FILE: hw/rtl/strr_front.sv
module strr_front
    import strr_pkg::*;
#(
    parameter int MAX_WORD_BYTES = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_word,
    input  logic i_q_full,
    output logic o_push,
    output t_cmd o_push_cmd
);

    localparam int SW = $clog2(MAX_WORD_BYTES + 1);
    localparam int CW = (SW > SRC_OFF_W) ? SW : SRC_OFF_W;

    logic [SW-1:0]        r_src,       n_src;
    logic [DST_OFF_W-1:0] r_dst,       n_dst;
    logic [3:0]           r_src_style, n_src_style;
    logic [3:0]           r_dst_style, n_dst_style;
    logic [3:0]           r_mask,      n_mask;
    logic [3:0]           r_set,       n_set;
    logic [2:0]           r_have,      n_have;
    logic [2:0]           r_need,      n_need;
    logic [DST_OFF_W-1:0] r_mark,      n_mark;
    logic                 r_stopped,   n_stopped;
    logic                 r_cur_hit,   n_cur_hit;
    logic [7:0]           r_pend [4];

    logic                 accept;
    logic                 live;
    logic                 unit_start;
    logic                 beg_hit, end_hit, cur_hit_now, cur_hit_end;
    logic [3:0][7:0]      e_bytes;
    logic [2:0]           e_n;
    logic [3:0]           e_mask, e_set;
    logic                 e_hit;
    logic [DST_OFF_W-1:0] e_mark;
    logic [3:0]           target;
    logic                 style_chg;
    logic [DST_OFF_W:0]   sum_s, sum_a;
    logic [DST_OFF_W-1:0] dst_style_done, dst_all_done, mark_done;
    logic [2:0]           need_v, have_v;
    logic [20:0]          cp;
    logic                 is_ctrl;

    function automatic logic [2:0] unit_len(input logic [7:0] b);
        logic [2:0] len;
        if (b >= 8'hC0 && b < 8'hE0) begin
            len = 3'd2;
        end else if (b >= 8'hE0 && b < 8'hF0) begin
            len = 3'd3;
        end else if (b >= 8'hF0 && b < 8'hF8) begin
            len = 3'd4;
        end else begin
            len = 3'd1;
        end
        return len;
    endfunction

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign live       = !r_stopped && (r_src < SW'(MAX_WORD_BYTES));
    assign unit_start = (r_have == 3'd0);

    assign beg_hit     = CW'(r_src) == CW'(i_cfg.range_begin);
    assign end_hit     = CW'(r_src) == CW'(i_cfg.range_end);
    assign cur_hit_now = CW'(r_src) == CW'(i_cfg.cursor_source);
    assign cur_hit_end = cur_hit_now;

    // unit being emitted: pending unit on end, or pending plus this byte
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (!i_in_word.action && (r_have[1:0] == 2'(i))) begin
                e_bytes[i] = i_in_word.in_byte;
            end else begin
                e_bytes[i] = r_pend[i];
            end
        end
        if (i_in_word.action) begin
            e_n    = r_have;
            e_mask = r_mask;
            e_set  = r_set;
            e_hit  = r_cur_hit;
            e_mark = r_mark;
        end else begin
            e_n = r_have + 3'd1;
            if (unit_start) begin
                e_mask = end_hit ? STYLE_FULL : (beg_hit ? i_cfg.style_keep_mask : r_mask);
                e_set  = end_hit ? 4'h0       : (beg_hit ? i_cfg.style_set_bits  : r_set);
                e_hit  = cur_hit_now;
                e_mark = cur_hit_now ? r_dst : r_mark;
            end else begin
                e_mask = r_mask;
                e_set  = r_set;
                e_hit  = r_cur_hit;
                e_mark = r_mark;
            end
        end
    end

    assign target    = (r_src_style & e_mask) | e_set;
    assign style_chg = (target != r_dst_style);
    assign sum_s     = {1'b0, r_dst} + 15'(style_chg);
    assign sum_a     = sum_s + 15'(e_n);
    assign dst_style_done = (sum_s > {1'b0, DST_MAX}) ? DST_MAX : sum_s[DST_OFF_W-1:0];
    assign dst_all_done   = (sum_a > {1'b0, DST_MAX}) ? DST_MAX : sum_a[DST_OFF_W-1:0];
    assign mark_done      = (style_chg && e_hit) ? dst_style_done : e_mark;

    assign need_v = unit_start ? unit_len(i_in_word.in_byte) : r_need;
    assign have_v = r_have + 3'd1;

    always_comb begin
        case (need_v)
            3'd2:    cp = {10'd0, e_bytes[0][4:0], e_bytes[1][5:0]};
            3'd3:    cp = {5'd0, e_bytes[0][3:0], e_bytes[1][5:0], e_bytes[2][5:0]};
            3'd4:    cp = {e_bytes[0][2:0], e_bytes[1][5:0], e_bytes[2][5:0],
                           e_bytes[3][5:0]};
            default: cp = {13'd0, e_bytes[0]};
        endcase
    end

    // lone bytes 0x80..0xFF print as they are
    assign is_ctrl = (cp <= 21'h1F || (cp >= 21'h7F && cp <= 21'h9F)
                      || cp == 21'h2028 || cp == 21'h2029)
                     && !(need_v == 3'd1 && cp >= 21'h80);

    always_comb begin
        n_src       = r_src;
        n_dst       = r_dst;
        n_src_style = r_src_style;
        n_dst_style = r_dst_style;
        n_mask      = r_mask;
        n_set       = r_set;
        n_have      = r_have;
        n_need      = r_need;
        n_mark      = r_mark;
        n_stopped   = r_stopped;
        n_cur_hit   = r_cur_hit;
        o_push      = 1'b0;
        o_push_cmd  = '0;
        o_push_cmd.style  = target;
        o_push_cmd.nbytes = e_n;
        o_push_cmd.bytes  = e_bytes;

        if (accept && i_in_word.action) begin
            o_push             = 1'b1;
            o_push_cmd.is_last = 1'b1;
            if (r_stopped) begin
                o_push_cmd.nbytes = 3'd0;
                o_push_cmd.cursor = r_mark;
            end else if (r_have != 3'd0) begin
                o_push_cmd.style_vld = style_chg;
                o_push_cmd.cursor    = cur_hit_end ? dst_all_done : mark_done;
            end else begin
                o_push_cmd.nbytes = 3'd0;
                o_push_cmd.cursor = cur_hit_end ? r_dst : r_mark;
            end
            // word done: back to reset values
            n_src       = '0;
            n_dst       = '0;
            n_src_style = '0;
            n_dst_style = '0;
            n_mask      = STYLE_FULL;
            n_set       = '0;
            n_have      = '0;
            n_need      = '0;
            n_mark      = '0;
            n_stopped   = 1'b0;
            n_cur_hit   = 1'b0;
        end else if (accept && live) begin
            n_src  = r_src + SW'(1);
            n_mask = e_mask;
            n_set  = e_set;
            n_mark = e_mark;
            if (have_v >= need_v) begin
                n_have    = '0;
                n_need    = '0;
                n_cur_hit = 1'b0;
                if (cp == 21'd0) begin
                    n_stopped = 1'b1;
                end else if (is_ctrl) begin
                    n_src_style = cp[3:0];
                end else begin
                    o_push               = 1'b1;
                    o_push_cmd.style_vld = style_chg;
                    n_dst_style          = target;
                    n_dst                = dst_all_done;
                    n_mark               = mark_done;
                end
            end else begin
                n_have    = have_v;
                n_need    = need_v;
                n_cur_hit = e_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src       <= '0;
            r_dst       <= '0;
            r_src_style <= '0;
            r_dst_style <= '0;
            r_mask      <= STYLE_FULL;
            r_set       <= '0;
            r_have      <= '0;
            r_need      <= '0;
            r_mark      <= '0;
            r_stopped   <= 1'b0;
            r_cur_hit   <= 1'b0;
        end else begin
            r_src       <= n_src;
            r_dst       <= n_dst;
            r_src_style <= n_src_style;
            r_dst_style <= n_dst_style;
            r_mask      <= n_mask;
            r_set       <= n_set;
            r_have      <= n_have;
            r_need      <= n_need;
            r_mark      <= n_mark;
            r_stopped   <= n_stopped;
            r_cur_hit   <= n_cur_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !i_in_word.action && live) begin
            r_pend[r_have[1:0]] <= i_in_word.in_byte;
        end
    end

endmodule

FILE: hw/rtl/strr_queue.sv
module strr_queue
    import strr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, n_wr;
    logic [Q_AW-1:0] r_rd, n_rd;
    logic [Q_CW-1:0] r_cnt, n_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = do_push ? Q_AW'((32'(r_wr) + 1) % Q_DEPTH) : r_wr;
        n_rd  = do_pop  ? Q_AW'((32'(r_rd) + 1) % Q_DEPTH) : r_rd;
        n_cnt = r_cnt + Q_CW'(do_push) - Q_CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

endmodule

FILE: hw/rtl/strr_back.sv
module strr_back
    import strr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_cmd i_head,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_word
);

    logic       r_out_valid, n_out_valid;
    t_out       r_out,       n_out;
    logic [2:0] r_idx,       n_idx;
    logic [2:0] total;
    logic [2:0] k;
    logic       adv, take;
    t_out       word;

    assign total = 3'(i_head.style_vld) + i_head.nbytes + 3'(i_head.is_last);
    assign k     = r_idx - 3'(i_head.style_vld);
    assign adv   = !r_out_valid || i_out_ready;
    assign take  = adv && !i_empty;
    assign o_pop = take && (r_idx == total - 3'd1);

    always_comb begin
        word = '0;
        if (i_head.style_vld && r_idx == 3'd0) begin
            word.out_byte   = STYLE_FLAG | {4'h0, i_head.style};
            word.byte_valid = 1'b1;
        end else if (k < i_head.nbytes) begin
            word.out_byte   = i_head.bytes[k[1:0]];
            word.byte_valid = 1'b1;
        end else begin
            word.cursor_dest = i_head.cursor;
            word.last        = 1'b1;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_idx       = r_idx;
        if (take) begin
            n_out_valid = 1'b1;
            n_out       = word;
            n_idx       = o_pop ? 3'd0 : r_idx + 3'd1;
        end else if (adv) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
